### hw/rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the strided pattern search unit
// Store sizes, field widths, command and register codes, and the
// controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sps_pkg;

    // store sizes
    localparam int ARG_DEPTH = 256;
    localparam int PAT_DEPTH = 32;
    localparam int ARG_AW    = $clog2(ARG_DEPTH);
    localparam int PAT_AW    = $clog2(PAT_DEPTH);

    // field widths
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 8;
    localparam int PLEN_W    = 6;
    localparam int LEN_W     = 9;
    localparam int STRIDE_W  = 7;
    localparam int MOFF_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;

    // candidate offset register, wide enough for one step past the end
    localparam int OFF_W     = ARG_AW + 2;

    // item commands
    typedef enum logic [1:0] {
        CMD_WR_ARG = 2'd0,
        CMD_WR_PAT = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NONE   = 2'd3
    } item_cmd_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ARG_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE  = 2'd1;

    // controller states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_ISSUE = 6'b001000,
        ST_CMP   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic load_search;
        logic set_found;
        logic set_miss;
        logic inc_k;
        logic next_off;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic plen_bad;
        logic plen_zero;
        logic off_fits;
        logic bytes_eq;
        logic k_last;
        logic out_free;
    } dp_status_t;

endpackage

### hw/rtl/sps_ram.sv
// ----------------------------------------------------------------------------
// sps_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/sps_ctrl.sv
// ----------------------------------------------------------------------------
// sps_ctrl: search sequencer
// Accepts requests, walks candidate offsets and pattern bytes, and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module sps_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  sps_pkg::dp_status_t status,
    output sps_pkg::ctrl_cmd_t  cmd
);

    sps_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sps_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == sps_pkg::ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.take   = s_valid && s_ready;
        unique case (state_reg)
            sps_pkg::ST_IDLE: begin
                if (s_valid && s_cmd == sps_pkg::CMD_SEARCH) begin
                    cmd.load_search = 1'b1;
                    state_next      = sps_pkg::ST_SETUP;
                end
            end
            sps_pkg::ST_SETUP: begin
                priority if (status.plen_bad) begin
                    cmd.set_miss = 1'b1;
                    state_next   = sps_pkg::ST_DONE;
                end else if (status.plen_zero) begin
                    cmd.set_found = 1'b1;
                    state_next    = sps_pkg::ST_DONE;
                end else begin
                    state_next = sps_pkg::ST_CHECK;
                end
            end
            sps_pkg::ST_CHECK: begin
                if (status.off_fits) begin
                    state_next = sps_pkg::ST_ISSUE;
                end else begin
                    cmd.set_miss = 1'b1;
                    state_next   = sps_pkg::ST_DONE;
                end
            end
            sps_pkg::ST_ISSUE: begin
                state_next = sps_pkg::ST_CMP;
            end
            sps_pkg::ST_CMP: begin
                priority if (!status.bytes_eq) begin
                    cmd.next_off = 1'b1;
                    state_next   = sps_pkg::ST_CHECK;
                end else if (status.k_last) begin
                    cmd.set_found = 1'b1;
                    state_next    = sps_pkg::ST_DONE;
                end else begin
                    cmd.inc_k  = 1'b1;
                    state_next = sps_pkg::ST_ISSUE;
                end
            end
            sps_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = sps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/sps_dp.sv
// ----------------------------------------------------------------------------
// sps_dp: search datapath
// Holds the configuration registers, both byte stores, the offset and
// pattern counters, the byte comparator and the output register.
// ----------------------------------------------------------------------------
module sps_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [sps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sps_pkg::CFG_W-1:0]           cfg_data,
    input  logic [1:0]                          s_cmd,
    input  logic [sps_pkg::IDX_W-1:0]           s_byte_index,
    input  logic [sps_pkg::BYTE_W-1:0]          s_byte_value,
    input  logic [sps_pkg::PLEN_W-1:0]          s_pattern_length,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_found,
    output logic [sps_pkg::MOFF_W-1:0]          m_match_offset,
    input  sps_pkg::ctrl_cmd_t                  cmd,
    output sps_pkg::dp_status_t                 status
);

    logic [sps_pkg::LEN_W-1:0]    arg_len_reg;
    logic [sps_pkg::STRIDE_W-1:0] stride_reg;
    logic [sps_pkg::LEN_W-1:0]    len_reg;
    logic [sps_pkg::STRIDE_W-1:0] step_reg;
    logic [sps_pkg::PLEN_W-1:0]   plen_reg;
    logic [sps_pkg::OFF_W-1:0]    off_reg;
    logic [sps_pkg::PAT_AW-1:0]   k_reg;
    logic                         found_reg;
    logic                         m_valid_reg;
    logic                         m_found_reg;
    logic [sps_pkg::MOFF_W-1:0]   m_offset_reg;

    logic [sps_pkg::LEN_W-1:0]    len_sat;
    logic [sps_pkg::OFF_W:0]      off_end;
    logic [sps_pkg::OFF_W-1:0]    arg_pos;
    logic [sps_pkg::PLEN_W:0]     k_plus;
    logic                         arg_we;
    logic                         pat_we;
    logic [sps_pkg::BYTE_W-1:0]   arg_rdata;
    logic [sps_pkg::BYTE_W-1:0]   pat_rdata;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arg_len_reg <= '0;
            stride_reg  <= sps_pkg::STRIDE_W'(1);
        end else if (cfg_valid) begin
            if (cfg_index == sps_pkg::CFG_ARG_LEN) begin
                arg_len_reg <= cfg_data[sps_pkg::LEN_W-1:0];
            end else if (cfg_index == sps_pkg::CFG_STRIDE) begin
                stride_reg <= cfg_data[sps_pkg::STRIDE_W-1:0];
            end
        end
    end

    // clamp the argument length to the store size
    assign len_sat = (32'(arg_len_reg) > sps_pkg::ARG_DEPTH)
                   ? sps_pkg::LEN_W'(sps_pkg::ARG_DEPTH) : arg_len_reg;

    // store writes, out-of-range positions dropped
    assign arg_we = cmd.take && s_cmd == sps_pkg::CMD_WR_ARG
                 && 32'(s_byte_index) < sps_pkg::ARG_DEPTH;
    assign pat_we = cmd.take && s_cmd == sps_pkg::CMD_WR_PAT
                 && 32'(s_byte_index) < sps_pkg::PAT_DEPTH;

    assign arg_pos = off_reg + sps_pkg::OFF_W'(k_reg);

    sps_ram #(
        .WIDTH (sps_pkg::BYTE_W),
        .DEPTH (sps_pkg::ARG_DEPTH)
    ) u_arg_ram (
        .aclk  (aclk),
        .we    (arg_we),
        .waddr (sps_pkg::ARG_AW'(s_byte_index)),
        .wdata (s_byte_value),
        .raddr (arg_pos[sps_pkg::ARG_AW-1:0]),
        .rdata (arg_rdata)
    );

    sps_ram #(
        .WIDTH (sps_pkg::BYTE_W),
        .DEPTH (sps_pkg::PAT_DEPTH)
    ) u_pat_ram (
        .aclk  (aclk),
        .we    (pat_we),
        .waddr (sps_pkg::PAT_AW'(s_byte_index)),
        .wdata (s_byte_value),
        .raddr (k_reg),
        .rdata (pat_rdata)
    );

    // search registers: latch request, advance byte and offset counters
    always_ff @(posedge aclk) begin
        if (cmd.load_search) begin
            len_reg  <= len_sat;
            step_reg <= (stride_reg == '0) ? sps_pkg::STRIDE_W'(1) : stride_reg;
            plen_reg <= s_pattern_length;
            off_reg  <= '0;
            k_reg    <= '0;
        end else if (cmd.next_off) begin
            off_reg <= off_reg + sps_pkg::OFF_W'(step_reg);
            k_reg   <= '0;
        end else if (cmd.inc_k) begin
            k_reg <= k_reg + sps_pkg::PAT_AW'(1);
        end
        if (cmd.set_found) begin
            found_reg <= 1'b1;
        end else if (cmd.set_miss) begin
            found_reg <= 1'b0;
        end
    end

    // status toward the controller
    assign off_end = {1'b0, off_reg} + (sps_pkg::OFF_W + 1)'(plen_reg);
    assign k_plus  = {1'b0, (sps_pkg::PLEN_W)'(k_reg)} + (sps_pkg::PLEN_W + 1)'(1);

    always_comb begin
        status           = '0;
        status.plen_bad  = 32'(plen_reg) > sps_pkg::PAT_DEPTH;
        status.plen_zero = (plen_reg == '0);
        status.off_fits  = off_end <= (sps_pkg::OFF_W + 1)'(len_reg);
        status.bytes_eq  = (arg_rdata == pat_rdata);
        status.k_last    = (k_plus == {1'b0, plen_reg});
        status.out_free  = !m_valid_reg || m_ready;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_found_reg  <= found_reg;
            m_offset_reg <= found_reg ? off_reg[sps_pkg::MOFF_W-1:0] : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_match_offset = m_offset_reg;

endmodule

### hw/rtl/strided_pattern_search_unit.sv
// Sequence: a search request is taken, then set up; each candidate offset is
// checked, each pattern byte is read from both RAMs and then compared, and the
// result is loaded into the output register.
// Throughput: one write per cycle while idle; one search at a time, input held
// while the search runs or while an earlier result waits in the output register.
// Reset: clears control state, argument length to 0, stride to 1; stores kept.
// ----------------------------------------------------------------------------
// strided_pattern_search_unit: strided first-match byte pattern search
// Fills argument and pattern stores from write requests and reports the
// first stride-aligned offset at which the pattern matches.
// ----------------------------------------------------------------------------
module strided_pattern_search_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sps_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [sps_pkg::IDX_W-1:0]     s_byte_index,
    input  logic [sps_pkg::BYTE_W-1:0]    s_byte_value,
    input  logic [sps_pkg::PLEN_W-1:0]    s_pattern_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [sps_pkg::MOFF_W-1:0]    m_match_offset
);

    sps_pkg::ctrl_cmd_t  cmd;
    sps_pkg::dp_status_t status;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    sps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .status  (status),
        .cmd     (cmd)
    );

    sps_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_cmd            (s_cmd),
        .s_byte_index     (s_byte_index),
        .s_byte_value     (s_byte_value),
        .s_pattern_length (s_pattern_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_match_offset   (m_match_offset),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
